### sv/reol_pkg.sv
package reol_pkg;

    localparam int ENTRY_COUNT = 10;
    localparam int SIZE_BITS   = 16;
    localparam int ADDR_BITS   = 32;
    localparam int OFF_BITS    = 20;
    localparam int EIDX_BITS   = 4;
    localparam int BOFF_BITS   = 16;

    localparam int IDX_BITS = $clog2(ENTRY_COUNT);
    localparam int CNT_BITS = $clog2(ENTRY_COUNT + 1);
    localparam int REM_BITS = (OFF_BITS > SIZE_BITS) ? OFF_BITS : SIZE_BITS;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_FIND = 1'b1;

    typedef logic [IDX_BITS-1:0] t_idx;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_BITS-1:0] size;
    } t_slot;

    typedef struct packed {
        logic  en;
        t_idx  idx;
        t_slot data;
    } t_wr_req;

    typedef struct packed {
        logic en;
        t_idx idx;
    } t_rd_req;

    typedef struct packed {
        logic                 found;
        logic [EIDX_BITS-1:0] entry_index;
        logic [ADDR_BITS-1:0] hit_addr;
        logic [SIZE_BITS-1:0] hit_size;
        logic [BOFF_BITS-1:0] byte_offset;
        logic                 ring_full;
    } t_result;

    function automatic t_idx next_slot(input t_idx i);
        t_idx n;
        if (i == t_idx'(ENTRY_COUNT - 1)) begin
            n = '0;
        end else begin
            n = i + t_idx'(1);
        end
        return n;
    endfunction

endpackage

### sv/reol_ring_mem.sv
module reol_ring_mem (
    input  logic             i_clk,
    input  reol_pkg::t_wr_req i_wr,
    input  reol_pkg::t_rd_req i_rd,
    output reol_pkg::t_slot   o_rd_data
);

    reol_pkg::t_slot mem [reol_pkg::ENTRY_COUNT];
    reol_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/reol_walk.sv
module reol_walk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_mode,
    input  logic [reol_pkg::ADDR_BITS-1:0]     i_entry_addr,
    input  logic [reol_pkg::SIZE_BITS-1:0]     i_entry_size,
    input  logic [reol_pkg::OFF_BITS-1:0]      i_char_offset,
    input  logic                               i_out_free,
    input  reol_pkg::t_slot                    i_rd_data,
    output logic                               o_idle,
    output reol_pkg::t_wr_req                  o_wr,
    output reol_pkg::t_rd_req                  o_rd,
    output reol_pkg::t_result                  o_res,
    output logic                               o_res_valid
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                             r_state, n_state;
    reol_pkg::t_idx                     r_wr_idx, n_wr_idx;
    reol_pkg::t_idx                     r_rd_idx, n_rd_idx;
    logic                               r_full, n_full;
    reol_pkg::t_idx                     r_idx, n_idx;
    logic [reol_pkg::CNT_BITS-1:0]      r_left, n_left;
    logic [reol_pkg::REM_BITS-1:0]      r_rem, n_rem;
    reol_pkg::t_result                  r_res, n_res;

    logic [reol_pkg::IDX_BITS:0]        span;
    logic [reol_pkg::CNT_BITS-1:0]      count;
    logic [reol_pkg::REM_BITS-1:0]      slot_size;
    logic                               hit;
    logic                               is_add;
    logic                               is_find;
    reol_pkg::t_idx                     wr_next;

    assign is_add  = i_start && (i_mode == reol_pkg::MODE_ADD);
    assign is_find = i_start && (i_mode == reol_pkg::MODE_FIND);

    // Number of stored entries; the ring holds all slots once the full flag is set.
    always_comb begin
        if (r_wr_idx >= r_rd_idx) begin
            span = {1'b0, r_wr_idx} - {1'b0, r_rd_idx};
        end else begin
            span = {1'b0, r_wr_idx} + (reol_pkg::IDX_BITS+1)'(reol_pkg::ENTRY_COUNT)
                   - {1'b0, r_rd_idx};
        end
        if (r_full) begin
            count = reol_pkg::CNT_BITS'(reol_pkg::ENTRY_COUNT);
        end else begin
            count = reol_pkg::CNT_BITS'(span);
        end
    end

    assign slot_size = reol_pkg::REM_BITS'(i_rd_data.size);
    assign hit       = r_rem < slot_size;
    assign wr_next   = reol_pkg::next_slot(r_wr_idx);

    always_comb begin
        o_wr.en        = is_add;
        o_wr.idx       = r_wr_idx;
        o_wr.data.addr = i_entry_addr;
        o_wr.data.size = i_entry_size;

        o_rd.en  = (is_find && (count != '0))
                   || ((r_state == S_WALK) && !hit && (r_left > reol_pkg::CNT_BITS'(1)));
        o_rd.idx = (r_state == S_IDLE) ? r_rd_idx : reol_pkg::next_slot(r_idx);
    end

    always_comb begin
        n_state  = r_state;
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_full   = r_full;
        n_idx    = r_idx;
        n_left   = r_left;
        n_rem    = r_rem;
        n_res    = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (is_add) begin
                    // An add into a full ring drops the oldest entry.
                    n_wr_idx = wr_next;
                    if (r_full) begin
                        n_rd_idx = reol_pkg::next_slot(r_rd_idx);
                    end
                    n_full = (wr_next == n_rd_idx);
                end else if (is_find) begin
                    n_res           = '0;
                    n_res.ring_full = r_full;
                    n_idx           = r_rd_idx;
                    n_left          = count;
                    n_rem           = reol_pkg::REM_BITS'(i_char_offset);
                    n_state         = (count == '0) ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                if (hit) begin
                    n_res.found       = 1'b1;
                    n_res.entry_index = reol_pkg::EIDX_BITS'(r_idx);
                    n_res.hit_addr    = i_rd_data.addr;
                    n_res.hit_size    = i_rd_data.size;
                    n_res.byte_offset = reol_pkg::BOFF_BITS'(r_rem);
                    n_state           = S_DONE;
                end else if (r_left == reol_pkg::CNT_BITS'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_rem  = r_rem - slot_size;
                    n_left = r_left - reol_pkg::CNT_BITS'(1);
                    n_idx  = reol_pkg::next_slot(r_idx);
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_full   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_full   <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_left <= n_left;
        r_rem  <= n_rem;
        r_res  <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res       = r_res;
    assign o_res_valid = (r_state == S_DONE);

endmodule

### sv/ring_entry_offset_lookup.sv
// Ring of address/size descriptors with a byte-offset lookup. An add (mode 0) stores
// a descriptor at the write slot and gives no result; once the ring is full each add
// overwrites the oldest entry. A find (mode 1) walks the stored entries from the
// oldest, one descriptor memory read per cycle, and returns one result; the walk
// stops at the first hit or after the last stored entry, and is paced by the single
// read port of the descriptor memory. The block takes one item at a time; a finished
// result sits in an output register, so the next item is accepted while it waits to
// be taken.
module ring_entry_offset_lookup (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_mode,
    input  logic [reol_pkg::ADDR_BITS-1:0]     i_entry_addr,
    input  logic [reol_pkg::SIZE_BITS-1:0]     i_entry_size,
    input  logic [reol_pkg::OFF_BITS-1:0]      i_char_offset,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_found,
    output logic [reol_pkg::EIDX_BITS-1:0]     o_entry_index,
    output logic [reol_pkg::ADDR_BITS-1:0]     o_hit_addr,
    output logic [reol_pkg::SIZE_BITS-1:0]     o_hit_size,
    output logic [reol_pkg::BOFF_BITS-1:0]     o_byte_offset,
    output logic                               o_ring_full
);

    reol_pkg::t_wr_req  wr;
    reol_pkg::t_rd_req  rd;
    reol_pkg::t_slot    rd_data;
    reol_pkg::t_result  res;
    logic               res_valid;
    logic               idle;
    logic               out_free;
    logic               start;

    logic               r_out_valid;
    reol_pkg::t_result  r_out;

    assign start    = i_valid && idle;
    assign out_free = !r_out_valid || i_ready;

    reol_ring_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    reol_walk u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_mode        (i_mode),
        .i_entry_addr  (i_entry_addr),
        .i_entry_size  (i_entry_size),
        .i_char_offset (i_char_offset),
        .i_out_free    (out_free),
        .i_rd_data     (rd_data),
        .o_idle        (idle),
        .o_wr          (wr),
        .o_rd          (rd),
        .o_res         (res),
        .o_res_valid   (res_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    assign o_ready       = idle;
    assign o_valid       = r_out_valid;
    assign o_found       = r_out.found;
    assign o_entry_index = r_out.entry_index;
    assign o_hit_addr    = r_out.hit_addr;
    assign o_hit_size    = r_out.hit_size;
    assign o_byte_offset = r_out.byte_offset;
    assign o_ring_full   = r_out.ring_full;

endmodule

### sv/reol_checker.sv
module reol_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic                               o_found,
    input logic [reol_pkg::EIDX_BITS-1:0]     o_entry_index,
    input logic [reol_pkg::ADDR_BITS-1:0]     o_hit_addr,
    input logic [reol_pkg::SIZE_BITS-1:0]     o_hit_size,
    input logic [reol_pkg::BOFF_BITS-1:0]     o_byte_offset,
    input logic                               o_ring_full
);

    // A stalled result keeps every field.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_entry_index)
            && $stable(o_hit_addr) && $stable(o_hit_size) && $stable(o_byte_offset)
            && $stable(o_ring_full))
        else $error("result changed while stalled");

    // A miss reports zeros in every field but the full flag.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_entry_index == '0 && o_hit_addr == '0
            && o_hit_size == '0 && o_byte_offset == '0)
        else $error("miss result carries nonzero fields");

    // A hit lies inside its entry, in a real slot.
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> reol_pkg::SIZE_BITS'(o_byte_offset) < o_hit_size
            && 32'(o_entry_index) < 32'(reol_pkg::ENTRY_COUNT))
        else $error("hit offset or slot out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind ring_entry_offset_lookup reol_checker u_reol_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_found       (o_found),
    .o_entry_index (o_entry_index),
    .o_hit_addr    (o_hit_addr),
    .o_hit_size    (o_hit_size),
    .o_byte_offset (o_byte_offset),
    .o_ring_full   (o_ring_full)
);
